[design/lpsm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lpsm_pkg;

    localparam int SAMPLE_BITS_DEF   = 10;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int CFG_W  = 10;
    localparam int CFG_IW = 2;
    localparam int DIST_W = 9;

    localparam logic [CFG_IW-1:0] CFG_DARK_THRESHOLD = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_LINE_MINIMUM   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_CMD_MINIMUM    = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_SPACING        = 2'd3;

    localparam logic [9:0] DARK_THRESHOLD_RST = 10'd50;
    localparam logic [2:0] LINE_MINIMUM_RST   = 3'd2;
    localparam logic [2:0] CMD_MINIMUM_RST    = 3'd5;
    localparam logic [5:0] SPACING_RST        = 6'd10;

    localparam logic signed [DIST_W-1:0] HELD_RST = -9'sd25;

    localparam int BEST_INIT = 2000;

    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } t_iter_req;

endpackage

`default_nettype wire

[design/lpsm_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lpsm_in_if #(
    parameter int SAMPLE_BITS = lpsm_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_0;
    logic [SAMPLE_BITS-1:0] sample_1;
    logic [SAMPLE_BITS-1:0] sample_2;
    logic [SAMPLE_BITS-1:0] sample_3;
    logic [SAMPLE_BITS-1:0] sample_4;
    logic [SAMPLE_BITS-1:0] sample_5;

    modport source (output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                    sample_5, input ready);
    modport sink   (input valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                    sample_5, output ready);
endinterface

interface lpsm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [lpsm_pkg::DIST_W-1:0]  distance_mm;
    logic                                line_lost;
    logic                                command_found;

    modport source (output valid, distance_mm, line_lost, command_found, input ready);
    modport sink   (input valid, distance_mm, line_lost, command_found, output ready);
endinterface

`default_nettype wire

[design/lpsm_iter.sv]
`timescale 1ns / 1ps
`default_nettype none

module lpsm_iter #(
    parameter int FB  = lpsm_pkg::FRACTION_BITS_DEF,
    parameter int DW  = 2 * lpsm_pkg::SAMPLE_BITS_DEF + 8,
    parameter int NW  = lpsm_pkg::SAMPLE_BITS_DEF + lpsm_pkg::FRACTION_BITS_DEF + 6,
    parameter int DNW = lpsm_pkg::SAMPLE_BITS_DEF + 6,
    parameter int RW  = lpsm_pkg::SAMPLE_BITS_DEF + 4 + lpsm_pkg::FRACTION_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lpsm_pkg::t_iter_req i_req,
    input  wire logic [DW-1:0]      i_rad,
    input  wire logic [NW-1:0]      i_num,
    input  wire logic [DNW-1:0]     i_den,
    output logic                    o_done,
    output logic [RW-1:0]           o_res
);

    localparam int UW  = RW + 3;
    localparam int SW  = DW + 2 * FB;
    localparam int CNW = $clog2(RW + 1);

    logic           r_busy;
    logic           r_done;
    logic           r_mode;
    logic [CNW-1:0] r_cnt;
    logic [UW-1:0]  r_rem;
    logic [RW-1:0]  r_res;
    logic [SW-1:0]  r_src;
    logic [DNW-1:0] r_den;

    logic [UW-1:0]  n_cur;
    logic [UW-1:0]  n_trial;
    logic           n_ge;

    always_comb begin
        if (r_mode) begin
            n_cur   = {r_rem[UW-3:0], r_src[SW-1:SW-2]};
            n_trial = UW'({r_res, 2'b01});
        end else begin
            n_cur   = {r_rem[UW-2:0], r_src[SW-1]};
            n_trial = UW'(r_den);
        end
        n_ge = n_cur >= n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_mode <= i_req.sqrt_mode;
                r_res  <= '0;
                r_den  <= i_den;
                if (i_req.sqrt_mode) begin
                    r_cnt <= CNW'(RW);
                    r_rem <= '0;
                    r_src <= {i_rad, {(2 * FB){1'b0}}};
                end else begin
                    r_cnt <= CNW'(FB + 1);
                    r_rem <= UW'(i_num[NW-2:FB+1]);
                    r_src <= {i_num[FB:0], {(SW - FB - 1){1'b0}}};
                end
            end else if (r_busy) begin
                r_rem  <= n_ge ? n_cur - n_trial : n_cur;
                r_res  <= {r_res[RW-2:0], n_ge};
                r_src  <= r_mode ? {r_src[SW-3:0], 2'b00} : {r_src[SW-2:0], 1'b0};
                r_cnt  <= r_cnt - CNW'(1);
                r_done <= (r_cnt == CNW'(1));
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

[design/line_position_spline_min.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  transfer when          payload
// i_in      in   valid & ready          sample_0 .. sample_5
// o_out     out  valid & ready          distance_mm, line_lost, command_found
// i_cfg     in   i_cfg_we               i_cfg_index, i_cfg_data
//
// lost line: the input transfer goes straight to the output state
// otherwise the result waits on the shared sqrt / divide unit
// (result width RW = SAMPLE_BITS+FRACTION_BITS+4) and the single shared multiplier
// i_in.ready is high only in idle; a finished result waits in the output register
// reset is synchronous, active low; held distance resets to -25

module line_position_spline_min #(
    parameter int SAMPLE_BITS   = lpsm_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = lpsm_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [lpsm_pkg::CFG_IW-1:0]   i_cfg_index,
    input  wire logic [lpsm_pkg::CFG_W-1:0]    i_cfg_data,
    lpsm_in_if.sink                            i_in,
    lpsm_out_if.source                         o_out
);

    localparam int SB   = SAMPLE_BITS;
    localparam int FB   = FRACTION_BITS;
    localparam int CW   = SB + 5;
    localparam int DW   = 2 * SB + 8;
    localparam int RW   = SB + 4 + FB;
    localparam int NW   = SB + FB + 6;
    localparam int DNW  = SB + 6;
    localparam int TW   = (SB + 7 > 13) ? SB + FB + 7 : FB + 13;
    localparam int MBW  = (CW > FB + 2) ? CW : FB + 2;
    localparam int PW   = TW + MBW;
    localparam int POSW = FB + 4;
    localparam int CMPW = (SB > 10) ? SB : 10;
    localparam int DSW  = lpsm_pkg::DIST_W;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_COEF = 5'd1;
    localparam logic [4:0] S_D1   = 5'd2;
    localparam logic [4:0] S_D2   = 5'd3;
    localparam logic [4:0] S_D3   = 5'd4;
    localparam logic [4:0] S_E1   = 5'd5;
    localparam logic [4:0] S_E2   = 5'd6;
    localparam logic [4:0] S_E3   = 5'd7;
    localparam logic [4:0] S_E4   = 5'd8;
    localparam logic [4:0] S_E5   = 5'd9;
    localparam logic [4:0] S_E6   = 5'd10;
    localparam logic [4:0] S_CMP  = 5'd11;
    localparam logic [4:0] S_NEXT = 5'd12;
    localparam logic [4:0] S_SQW  = 5'd13;
    localparam logic [4:0] S_RT   = 5'd14;
    localparam logic [4:0] S_RC   = 5'd15;
    localparam logic [4:0] S_DVW  = 5'd16;
    localparam logic [4:0] S_F1   = 5'd17;
    localparam logic [4:0] S_F2   = 5'd18;
    localparam logic [4:0] S_F3   = 5'd19;
    localparam logic [4:0] S_OUT  = 5'd20;

    localparam logic [1:0] CAND_ZERO = 2'd0;
    localparam logic [1:0] CAND_R1   = 2'd1;
    localparam logic [1:0] CAND_R2   = 2'd2;
    localparam logic [1:0] CAND_ONE  = 2'd3;

    localparam logic [2:0] LAST_IV = 3'd4;

    // configuration
    logic [9:0] r_thr;
    logic [2:0] r_line_min;
    logic [2:0] r_cmd_min;
    logic [5:0] r_spacing;

    logic [4:0]                r_state;
    logic [SB-1:0]             r_win [0:7];
    logic [2:0]                r_iv;
    logic [1:0]                r_cand;
    logic signed [CW-1:0]      r_c3;
    logic signed [CW-1:0]      r_c2;
    logic signed [CW-1:0]      r_c1;
    logic [SB-1:0]             r_p1;
    logic [DNW-1:0]            r_den;
    logic                      r_neg;
    logic signed [DW-1:0]      r_disc;
    logic [RW-1:0]             r_s;
    logic signed [NW-1:0]      r_num;
    logic [FB:0]               r_u;
    logic signed [TW-1:0]      r_t;
    logic signed [PW-1:0]      r_prod;
    logic signed [TW-1:0]      r_best;
    logic [POSW-1:0]           r_bpos;
    logic                      r_lost;
    logic                      r_cmd;
    logic signed [DSW-1:0]     r_held;
    logic                      r_ovalid;
    logic signed [DSW-1:0]     r_odist;
    logic                      r_olost;
    logic                      r_ocmd;

    logic [SB-1:0]             samp [0:5];
    logic [2:0]                dark_c;
    logic                      lost_c;
    logic signed [CW-1:0]      w0, w1, w2, w3;
    logic signed [CW-1:0]      c3_c, c2_c, c1_c;
    logic signed [CW:0]        c3x3_c;
    logic signed [CW:0]        c3x3_r;
    logic signed [TW-1:0]      ma;
    logic signed [MBW-1:0]     mb;
    logic signed [PW-1:0]      prod_c;
    logic signed [PW-1:0]      prod_adj;
    logic signed [PW-1:0]      prod_sh;
    logic signed [TW-1:0]      tr_c;
    logic signed [TW-1:0]      c2f, c1f, p1f;
    logic signed [NW-1:0]      nbase, num_c;
    logic                      plus_s;
    logic [NW-1:0]             den_f;
    logic [POSW-1:0]           pos_c;
    lpsm_pkg::t_iter_req       iter_req;
    logic                      iter_done;
    logic [RW-1:0]             iter_res;

    assign samp[0] = i_in.sample_0;
    assign samp[1] = i_in.sample_1;
    assign samp[2] = i_in.sample_2;
    assign samp[3] = i_in.sample_3;
    assign samp[4] = i_in.sample_4;
    assign samp[5] = i_in.sample_5;

    always_comb begin
        dark_c = '0;
        for (int k = 0; k < 6; k++) begin
            dark_c = dark_c + 3'(CMPW'(samp[k]) < CMPW'(r_thr));
        end
        lost_c = dark_c < r_line_min;
    end

    // spline coefficients of the current window
    always_comb begin
        w0 = $signed(CW'(r_win[0]));
        w1 = $signed(CW'(r_win[1]));
        w2 = $signed(CW'(r_win[2]));
        w3 = $signed(CW'(r_win[3]));
        c3_c = w3 - w0 + (w1 + (w1 <<< 1)) - (w2 + (w2 <<< 1));
        c2_c = (w0 <<< 1) - (w1 <<< 2) - w1 + (w2 <<< 2) - w3;
        c1_c = w2 - w0;
        c3x3_c = (CW+1)'(c3_c) + ((CW+1)'(c3_c) <<< 1);
        c3x3_r = (CW+1)'(r_c3) + ((CW+1)'(r_c3) <<< 1);
    end

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_D1: begin
                ma = TW'(r_c2);
                mb = MBW'(r_c2);
            end
            S_D2: begin
                ma = TW'(c3x3_r);
                mb = MBW'(r_c1);
            end
            S_E1: begin
                ma = TW'(r_c3);
                mb = $signed(MBW'(r_u));
            end
            S_E3, S_E5: begin
                ma = r_t;
                mb = $signed(MBW'(r_u));
            end
            S_F2: begin
                ma = r_t;
                mb = $signed(MBW'(r_spacing));
            end
            default: begin
                ma = r_t;
                mb = '0;
            end
        endcase
        prod_c = ma * mb;
    end

    // product scaled down by 2^FB, truncated toward zero
    always_comb begin
        prod_adj = r_prod + $signed({{(PW - FB){1'b0}}, {FB{r_prod[PW-1]}}});
        prod_sh  = prod_adj >>> FB;
        tr_c     = prod_sh[TW-1:0];
        c2f      = TW'($signed({r_c2, {FB{1'b0}}}));
        c1f      = TW'($signed({r_c1, {FB{1'b0}}}));
        p1f      = $signed(TW'({r_p1, 1'b0, {FB{1'b0}}}));
        nbase    = r_neg ? NW'(c2f) : -NW'(c2f);
        plus_s   = (r_cand == CAND_R1) != r_neg;
        num_c    = plus_s ? nbase + $signed(NW'(r_s)) : nbase - $signed(NW'(r_s));
        den_f    = {r_den, {FB{1'b0}}};
        pos_c    = POSW'({r_iv, {FB{1'b0}}}) + POSW'(r_u);
    end

    always_comb begin
        iter_req.start     = 1'b0;
        iter_req.sqrt_mode = 1'b0;
        if (r_state == S_NEXT && r_cand == CAND_ZERO && r_c3 != '0 && !r_disc[DW-1]) begin
            iter_req.start     = 1'b1;
            iter_req.sqrt_mode = 1'b1;
        end else if (r_state == S_RC && !r_num[NW-1] && $unsigned(r_num) <= den_f) begin
            iter_req.start = 1'b1;
        end
    end

    lpsm_iter #(
        .FB  (FB),
        .DW  (DW),
        .NW  (NW),
        .DNW (DNW),
        .RW  (RW)
    ) u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (iter_req),
        .i_rad   ($unsigned(r_disc)),
        .i_num   ($unsigned(r_num)),
        .i_den   (r_den),
        .o_done  (iter_done),
        .o_res   (iter_res)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= prod_c;
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ovalid   <= 1'b0;
            r_held     <= lpsm_pkg::HELD_RST;
            r_thr      <= lpsm_pkg::DARK_THRESHOLD_RST;
            r_line_min <= lpsm_pkg::LINE_MINIMUM_RST;
            r_cmd_min  <= lpsm_pkg::CMD_MINIMUM_RST;
            r_spacing  <= lpsm_pkg::SPACING_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lpsm_pkg::CFG_DARK_THRESHOLD: r_thr      <= i_cfg_data;
                    lpsm_pkg::CFG_LINE_MINIMUM:   r_line_min <= i_cfg_data[2:0];
                    lpsm_pkg::CFG_CMD_MINIMUM:    r_cmd_min  <= i_cfg_data[2:0];
                    lpsm_pkg::CFG_SPACING:        r_spacing  <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (r_ovalid && o_out.ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_win[0] <= samp[0];
                        for (int k = 0; k < 6; k++) begin
                            r_win[k+1] <= samp[k];
                        end
                        r_win[7] <= samp[5];
                        r_lost   <= lost_c;
                        r_cmd    <= !lost_c && (dark_c >= r_cmd_min);
                        r_best   <= TW'(lpsm_pkg::BEST_INIT) <<< FB;
                        r_bpos   <= '0;
                        r_iv     <= '0;
                        r_state  <= lost_c ? S_OUT : S_COEF;
                    end
                end
                S_COEF: begin
                    r_c3    <= c3_c;
                    r_c2    <= c2_c;
                    r_c1    <= c1_c;
                    r_p1    <= r_win[1];
                    r_neg   <= c3_c[CW-1];
                    r_den   <= c3_c[CW-1] ? DNW'(-c3x3_c) : DNW'(c3x3_c);
                    r_cand  <= CAND_ZERO;
                    r_u     <= '0;
                    r_state <= S_D1;
                end
                S_D1: r_state <= S_D2;
                S_D2: begin
                    r_disc  <= r_prod[DW-1:0];
                    r_state <= S_D3;
                end
                S_D3: begin
                    r_disc  <= r_disc - r_prod[DW-1:0];
                    r_state <= S_E1;
                end
                S_E1: r_state <= S_E2;
                S_E2: begin
                    r_t     <= r_prod[TW-1:0] + c2f;
                    r_state <= S_E3;
                end
                S_E3: r_state <= S_E4;
                S_E4: begin
                    r_t     <= tr_c + c1f;
                    r_state <= S_E5;
                end
                S_E5: r_state <= S_E6;
                S_E6: begin
                    r_t     <= tr_c + p1f;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_t < r_best) begin
                        r_best <= r_t;
                        r_bpos <= pos_c;
                    end
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    case (r_cand)
                        CAND_ZERO: begin
                            if (iter_req.start) begin
                                r_state <= S_SQW;
                            end else begin
                                r_u     <= (FB+1)'(1) << FB;
                                r_cand  <= CAND_ONE;
                                r_state <= S_E1;
                            end
                        end
                        CAND_R1: begin
                            r_cand  <= CAND_R2;
                            r_state <= S_RT;
                        end
                        CAND_R2: begin
                            r_u     <= (FB+1)'(1) << FB;
                            r_cand  <= CAND_ONE;
                            r_state <= S_E1;
                        end
                        default: begin
                            if (r_iv == LAST_IV) begin
                                r_state <= S_F1;
                            end else begin
                                for (int k = 0; k < 7; k++) begin
                                    r_win[k] <= r_win[k+1];
                                end
                                r_iv    <= r_iv + 3'd1;
                                r_state <= S_COEF;
                            end
                        end
                    endcase
                end
                S_SQW: begin
                    if (iter_done) begin
                        r_s     <= iter_res;
                        r_cand  <= CAND_R1;
                        r_state <= S_RT;
                    end
                end
                S_RT: begin
                    r_num   <= num_c;
                    r_state <= S_RC;
                end
                S_RC: begin
                    if (iter_req.start) begin
                        r_state <= S_DVW;
                    end else if (r_cand == CAND_R1) begin
                        r_cand  <= CAND_R2;
                        r_state <= S_RT;
                    end else begin
                        r_u     <= (FB+1)'(1) << FB;
                        r_cand  <= CAND_ONE;
                        r_state <= S_E1;
                    end
                end
                S_DVW: begin
                    if (iter_done) begin
                        r_u     <= iter_res[FB:0];
                        r_state <= S_E1;
                    end
                end
                S_F1: begin
                    r_t     <= $signed(TW'(r_bpos)) - (TW'(5) <<< (FB - 1));
                    r_state <= S_F2;
                end
                S_F2: r_state <= S_F3;
                S_F3: begin
                    r_held  <= tr_c[DSW-1:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_odist  <= r_held;
                        r_olost  <= r_lost;
                        r_ocmd   <= r_cmd;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_ovalid;
    assign o_out.distance_mm   = r_odist;
    assign o_out.line_lost     = r_olost;
    assign o_out.command_found = r_ocmd;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != S_IDLE))
        else $error("input transfer did not start work");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iter_done |-> (r_state == S_SQW || r_state == S_DVW))
        else $error("iterative unit finished outside a wait state");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.line_lost) |-> !o_out.command_found)
        else $error("command flagged on a lost line");

endmodule

`default_nettype wire

[tb/sv/line_position_spline_min_checker.sv]
`timescale 1ns / 1ps

module line_position_spline_min_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [lpsm_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [lpsm_pkg::CFG_W-1:0]  i_cfg_data,
    lpsm_in_if                               i_scan,
    lpsm_out_if                              i_fix,
    output int                               o_errors,
    output int                               o_pending
);
    import lpsm_pkg::*;

    localparam int FB = FRACTION_BITS_DEF;
    localparam longint ONE = longint'(1) << FB;

    typedef struct {
        logic signed [DIST_W-1:0] distance;
        logic                     lost;
        logic                     command;
    } t_fix;

    t_fix pending_fixes[$];

    logic [9:0]               dark_thr;
    logic [2:0]               lmin_cfg;
    logic [2:0]               cmd_min;
    logic [5:0]               spacing;
    logic signed [DIST_W-1:0] held_dist;

    function automatic longint frac_mul(input longint a, input longint u);
        longint unsigned mag;
        longint unsigned r;
        mag = (a < 0) ? longint'(-a) : longint'(a);
        r = (mag >> FB) * u + (((mag & (ONE - 1)) * u) >> FB);
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint scaled_sqrt(input longint unsigned d);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned pair;
        longint unsigned trial;
        rem = 0;
        root = 0;
        for (int k = 31 + FB; k >= 0; k--) begin
            pair = (k >= FB) ? ((d >> (2 * (k - FB))) & 3) : 0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 1;
            end else begin
                root = root << 1;
            end
        end
        return longint'(root);
    endfunction

    function automatic longint curve_at(input longint c3, c2, c1, p1, u);
        longint t;
        t = c3 * u + c2 * ONE;
        t = frac_mul(t, u) + c1 * ONE;
        t = frac_mul(t, u) + 2 * p1 * ONE;
        return t;
    endfunction

    function automatic t_fix locate_line(input logic [9:0] s [6]);
        t_fix f;
        longint p [8];
        int dark;
        longint lowest, lowest_pos, c3, c2, c1, base, disc, root, num, den, v, d;
        dark = 0;
        for (int i = 0; i < 6; i++) begin
            p[i + 1] = s[i];
            if (s[i] < dark_thr) dark++;
        end
        p[0] = p[1];
        p[7] = p[6];
        f.lost = dark < lmin_cfg;
        f.command = 1'b0;
        if (!f.lost) begin
            f.command = dark >= cmd_min;
            lowest = BEST_INIT * ONE;
            lowest_pos = 0;
            for (int i = 1; i < 6; i++) begin
                c3 = -p[i-1] + 3 * p[i] - 3 * p[i+1] + p[i+2];
                c2 = 2 * p[i-1] - 5 * p[i] + 4 * p[i+1] - p[i+2];
                c1 = p[i+1] - p[i-1];
                base = (i - 1) * ONE;
                disc = c2 * c2 - 3 * c3 * c1;
                v = curve_at(c3, c2, c1, p[i], 0);
                if (v < lowest) begin
                    lowest = v;
                    lowest_pos = base;
                end
                if (c3 != 0 && disc >= 0) begin
                    root = scaled_sqrt(disc);
                    for (int k = 0; k < 2; k++) begin
                        num = -c2 * ONE + ((k == 0) ? root : -root);
                        den = 3 * c3;
                        if (den < 0) begin
                            den = -den;
                            num = -num;
                        end
                        if (num >= 0 && num <= den * ONE) begin
                            v = curve_at(c3, c2, c1, p[i], num / den);
                            if (v < lowest) begin
                                lowest = v;
                                lowest_pos = base + num / den;
                            end
                        end
                    end
                end
                v = curve_at(c3, c2, c1, p[i], ONE);
                if (v < lowest) begin
                    lowest = v;
                    lowest_pos = base + ONE;
                end
            end
            d = (lowest_pos - 5 * (ONE / 2)) * longint'(spacing);
            held_dist = DIST_W'(d / ONE);
        end
        f.distance = held_dist;
        return f;
    endfunction

    always @(posedge i_clk) begin
        t_fix e;
        logic [9:0] s [6];
        if (!i_rst_n) begin
            dark_thr  <= DARK_THRESHOLD_RST;
            lmin_cfg  <= LINE_MINIMUM_RST;
            cmd_min   <= CMD_MINIMUM_RST;
            spacing   <= SPACING_RST;
            held_dist = HELD_RST;
            o_errors  <= 0;
            o_pending <= 0;
            pending_fixes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DARK_THRESHOLD: dark_thr <= i_cfg_data[9:0];
                    CFG_LINE_MINIMUM:   lmin_cfg <= i_cfg_data[2:0];
                    CFG_CMD_MINIMUM:    cmd_min  <= i_cfg_data[2:0];
                    CFG_SPACING:        spacing  <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (i_scan.valid && i_scan.ready) begin
                s = '{i_scan.sample_0, i_scan.sample_1, i_scan.sample_2,
                      i_scan.sample_3, i_scan.sample_4, i_scan.sample_5};
                pending_fixes.push_back(locate_line(s));
            end
            if (i_fix.valid && i_fix.ready) begin
                if (pending_fixes.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result transfer at %0t", $realtime);
                    o_errors <= o_errors + 1;
                end else begin
                    e = pending_fixes.pop_front();
                    if (i_fix.distance_mm !== e.distance || i_fix.line_lost !== e.lost ||
                        i_fix.command_found !== e.command) begin
                        if (o_errors < 10)
                            $display("mismatch at %0t: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                     $realtime, e.distance, e.lost, e.command,
                                     i_fix.distance_mm, i_fix.line_lost, i_fix.command_found);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= pending_fixes.size();
        end
    end
endmodule

[tb/sv/line_position_spline_min_test.sv]
`timescale 1ns / 1ps

module line_position_spline_min_test;
    import lpsm_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CFG_IW-1:0]   cfg_index = CFG_DARK_THRESHOLD;
    logic [CFG_W-1:0]    cfg_data = '0;
    int                  errors;
    int                  pending;
    int                  cycles = 0;
    int                  idle_pct = 0;
    int                  stall_pct = 0;
    int                  cur_thr = 50;

    lpsm_in_if  scan_ch ();
    lpsm_out_if fix_ch ();

    line_position_spline_min i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .i_in(scan_ch), .o_out(fix_ch)
    );

    line_position_spline_min_checker i_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .i_scan(scan_ch), .i_fix(fix_ch), .o_errors(errors),
        .o_pending(pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        scan_ch.valid = 1'b0;
        {scan_ch.sample_0, scan_ch.sample_1, scan_ch.sample_2} = '0;
        {scan_ch.sample_3, scan_ch.sample_4, scan_ch.sample_5} = '0;
        fix_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL line_position_spline_min");
            $finish;
        end
    end

    always @(posedge i_clk)
        fix_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    task automatic send_scan(input logic [9:0] s [6]);
        while ($urandom_range(0, 99) < idle_pct) begin
            scan_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        scan_ch.valid    <= 1'b1;
        scan_ch.sample_0 <= s[0];
        scan_ch.sample_1 <= s[1];
        scan_ch.sample_2 <= s[2];
        scan_ch.sample_3 <= s[3];
        scan_ch.sample_4 <= s[4];
        scan_ch.sample_5 <= s[5];
        do @(posedge i_clk); while (!scan_ch.ready);
    endtask

    // wait for every result, then leave the block idle
    task automatic drain();
        scan_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] thr, lmin, cmin, sp);
        cfg_we <= 1'b1;
        cfg_index <= CFG_DARK_THRESHOLD;
        cfg_data <= thr;
        @(posedge i_clk);
        cfg_index <= CFG_LINE_MINIMUM;
        cfg_data <= lmin;
        @(posedge i_clk);
        cfg_index <= CFG_CMD_MINIMUM;
        cfg_data <= cmin;
        @(posedge i_clk);
        cfg_index <= CFG_SPACING;
        cfg_data <= sp;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        cur_thr = thr[9:0];
    endtask

    // dark dip around a random sensor over a bright floor
    task automatic send_line_scan();
        logic [9:0] s [6];
        int centre;
        int gap;
        int lo;
        centre = $urandom_range(0, 5);
        lo = (cur_thr > 0) ? cur_thr : 1;
        for (int i = 0; i < 6; i++) begin
            gap = (i > centre) ? i - centre : centre - i;
            if ($urandom_range(0, 99) < 15)
                s[i] = $urandom_range(0, 1023);
            else if (gap == 0)
                s[i] = $urandom_range(0, lo - 1 > 0 ? lo - 1 : 0);
            else if (gap == 1)
                s[i] = ($urandom_range(0, 1)) ? $urandom_range(0, lo + 100 > 1023 ? 1023 : lo + 100)
                                              : $urandom_range(0, 1023);
            else
                s[i] = $urandom_range(lo > 1023 ? 1023 : lo, 1023);
        end
        send_scan(s);
    endtask

    initial begin
        logic [9:0] s [6];
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings
        send_scan('{1023, 1023, 1023, 1023, 1023, 1023});
        send_scan('{0, 0, 0, 0, 0, 0});
        send_scan('{500, 500, 10, 10, 500, 500});
        send_scan('{0, 1023, 1023, 1023, 1023, 1023});
        send_scan('{1023, 1023, 1023, 1023, 1023, 0});
        send_scan('{0, 0, 1023, 1023, 1023, 1023});
        send_scan('{1023, 1023, 1023, 1023, 0, 0});
        send_scan('{1023, 0, 1023, 1023, 0, 1023});
        send_scan('{100, 40, 20, 30, 45, 200});
        send_scan('{40, 40, 40, 40, 40, 40});
        send_scan('{60, 10, 49, 10, 60, 1023});
        send_scan('{682, 341, 0, 0, 341, 682});
        send_scan('{1023, 1023, 1023, 1023, 1023, 1023});
        drain();

        set_regs(1023, 0, 7, 63);
        send_scan('{1023, 1023, 1023, 1023, 1023, 1023});
        send_scan('{1022, 1022, 1022, 1022, 1022, 1022});
        send_scan('{1022, 512, 0, 1023, 700, 300});
        send_scan('{0, 300, 600, 900, 1000, 1022});
        drain();
        set_regs(0, 0, 0, 0);
        send_scan('{1023, 800, 0, 0, 800, 1023});
        send_scan('{0, 1023, 0, 1023, 0, 1023});
        drain();
        set_regs(10'h3FF, 10'h3FE, 10'h3F9, 10'h3C1);
        send_scan('{0, 0, 0, 0, 0, 0});
        send_scan('{1023, 5, 5, 5, 5, 5});
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 34 : 82) : 0;
            stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 34 : 82) : 0;
            case (ph)
                0: set_regs(50, 2, 5, 10);
                1: set_regs(1023, 6, 6, 1);
                2: set_regs($urandom_range(0, 1023), $urandom_range(0, 7),
                            $urandom_range(0, 7), $urandom_range(0, 63));
                default: set_regs($urandom_range(20, 600), $urandom_range(0, 3),
                                  $urandom_range(2, 6), 63);
            endcase
            for (int n = 0; n < 245; n++) begin
                if ($urandom_range(0, 99) < 80) begin
                    send_line_scan();
                end else begin
                    foreach (s[i]) s[i] = $urandom_range(0, 1023);
                    send_scan(s);
                end
                if (n == 120 && ph == 0) begin
                    idle_pct = 0;
                    stall_pct = 0;
                    drain();
                    set_regs(200, 1, 4, 37);
                end
            end
            drain();
        end

        repeat (600) @(posedge i_clk);
        if (errors == 0)
            $display("PASS line_position_spline_min");
        else
            $display("FAIL line_position_spline_min");
        $finish;
    end
endmodule

[line_position_spline_min.f]
design/lpsm_pkg.sv
design/lpsm_if.sv
design/lpsm_iter.sv
design/line_position_spline_min.sv
tb/sv/line_position_spline_min_checker.sv
tb/sv/line_position_spline_min_test.sv
